### rtl/jsu_pkg.sv
// Package for the JSON string unescaper: types, codes and helper functions.
// No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_HEX3   = 3'd5,
    PH_BADHEX = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_CTRL       = 3'd1,
    ERR_BAD_ESC    = 3'd2,
    ERR_BAD_HEX    = 3'd3,
    ERR_TRUNC_UNI  = 3'd4,
    ERR_UNTERM_ESC = 3'd5,
    ERR_UNTERM_STR = 3'd6
  } err_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_U = 8'h75;

  // Command passed from front to back: one plain result or a code point.
  typedef struct packed {
    logic        utf8;
    logic [15:0] val;
    kind_t       kind;
    err_t        err;
  } cmd_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

### rtl/jsu_if.sv
// Channel interfaces of the JSON string unescaper: input bytes and results.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;
  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;
  modport source (output valid, output out_byte, output out_kind,
                  output out_error_code, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_kind,
                  input out_error_code, input out_last, output ready);
endinterface

### rtl/jsu_front.sv
// Front end: accepts input bytes, runs the escape phase machine, pushes commands.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  jsu_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output jsu_pkg::cmd_t    q_cmd
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic            acc_s;
  logic [4:0]      hv;
  logic [15:0]     acc_sh;
  logic [3:0]      bad_n;
  logic            push;
  jsu_pkg::cmd_t   cmd;
  logic            take;

  assign in_ch.ready = !q_full;
  assign take = in_ch.valid && in_ch.ready;
  assign hv = jsu_pkg::hex_value(in_ch.in_byte);
  assign acc_sh = {acc_r[11:0], hv[3:0]};
  assign bad_n = {1'b0, acc_r[2:0]} + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    push = 1'b0;
    acc_s = 1'b0;
    cmd.utf8 = 1'b0;
    cmd.val = {8'd0, in_ch.in_byte};
    cmd.kind = jsu_pkg::KIND_DATA;
    cmd.err = jsu_pkg::ERR_NONE;
    if (in_ch.in_end) begin
      push = 1'b1;
      cmd.val = 16'd0;
      cmd.kind = jsu_pkg::KIND_ERR;
      phase_nxt = jsu_pkg::PH_NORMAL;
      acc_nxt = 16'd0;
      unique case (phase_r)
        jsu_pkg::PH_ESCAPE: cmd.err = jsu_pkg::ERR_UNTERM_ESC;
        jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
        jsu_pkg::PH_BADHEX: cmd.err = jsu_pkg::ERR_TRUNC_UNI;
        default: cmd.err = jsu_pkg::ERR_UNTERM_STR;
      endcase
    end else begin
      unique case (phase_r)
        jsu_pkg::PH_ESCAPE: begin
          phase_nxt = jsu_pkg::PH_NORMAL;
          push = 1'b1;
          unique case (in_ch.in_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: ;
            jsu_pkg::CH_LC_B: cmd.val = 16'h0008;
            jsu_pkg::CH_LC_F: cmd.val = 16'h000C;
            jsu_pkg::CH_LC_N: cmd.val = 16'h000A;
            jsu_pkg::CH_LC_R: cmd.val = 16'h000D;
            jsu_pkg::CH_LC_T: cmd.val = 16'h0009;
            jsu_pkg::CH_LC_U: begin
              push = 1'b0;
              phase_nxt = jsu_pkg::PH_HEX0;
              acc_nxt = 16'd0;
            end
            default: begin
              cmd.val = 16'd0;
              cmd.kind = jsu_pkg::KIND_ERR;
              cmd.err = jsu_pkg::ERR_BAD_ESC;
              acc_nxt = 16'd0;
            end
          endcase
        end
        jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
          if (!hv[4]) begin
            if (phase_r == jsu_pkg::PH_HEX3) begin
              acc_s = 1'b1;
            end else begin
              phase_nxt = jsu_pkg::PH_BADHEX;
              acc_nxt = {13'd0, phase_r - 3'd1};
            end
          end else if (phase_r == jsu_pkg::PH_HEX3) begin
            push = 1'b1;
            cmd.utf8 = 1'b1;
            cmd.val = acc_sh;
            phase_nxt = jsu_pkg::PH_NORMAL;
            acc_nxt = 16'd0;
          end else begin
            phase_nxt = jsu_pkg::phase_t'(phase_r + 3'd1);
            acc_nxt = acc_sh;
          end
        end
        jsu_pkg::PH_BADHEX: begin
          if (bad_n >= 4'd4) acc_s = 1'b1;
          else acc_nxt = {12'd0, bad_n};
        end
        default: begin
          phase_nxt = jsu_pkg::PH_NORMAL;
          push = 1'b1;
          if (in_ch.in_byte == jsu_pkg::CH_QUOTE) begin
            cmd.val = 16'd0;
            cmd.kind = jsu_pkg::KIND_END;
          end else if (in_ch.in_byte < jsu_pkg::CH_SPACE) begin
            cmd.val = 16'd0;
            cmd.kind = jsu_pkg::KIND_ERR;
            cmd.err = jsu_pkg::ERR_CTRL;
            acc_nxt = 16'd0;
          end else if (in_ch.in_byte == jsu_pkg::CH_BSLASH) begin
            push = 1'b0;
            phase_nxt = jsu_pkg::PH_ESCAPE;
          end
        end
      endcase
      // bad hex digit error at the fourth digit byte
      if (acc_s) begin
        push = 1'b1;
        cmd.utf8 = 1'b0;
        cmd.val = 16'd0;
        cmd.kind = jsu_pkg::KIND_ERR;
        cmd.err = jsu_pkg::ERR_BAD_HEX;
        phase_nxt = jsu_pkg::PH_NORMAL;
        acc_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_NORMAL;
      acc_r <= 16'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign q_push = take && push;
  assign q_cmd = cmd;

endmodule

### rtl/jsu_queue.sv
// Short command queue between front and back ends.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output jsu_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_cmd = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

### rtl/jsu_back.sv
// Back end: expands queued commands into result bytes, incl. UTF-8 encoding.
// Depends on jsu_pkg and jsu_out_if.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  jsu_out_if.source     out_ch
);

  logic [1:0]    seg_r;
  logic [1:0]    last_seg;
  logic          load;
  logic [7:0]    byte_nxt;
  logic [15:0]   cp;
  logic          out_valid_r;
  logic [7:0]    byte_r;
  jsu_pkg::kind_t kind_r;
  jsu_pkg::err_t  err_r;
  logic          last_r;

  assign cp = q_cmd.val;

  always_comb begin
    if (!q_cmd.utf8) last_seg = 2'd0;
    else if (cp[15:11] != 5'd0) last_seg = 2'd2;
    else if (cp[10:7] != 4'd0) last_seg = 2'd1;
    else last_seg = 2'd0;
    byte_nxt = cp[7:0];
    if (q_cmd.utf8) begin
      unique case (last_seg)
        2'd2: begin
          unique case (seg_r)
            2'd0: byte_nxt = {4'hE, cp[15:12]};
            2'd1: byte_nxt = {2'b10, cp[11:6]};
            default: byte_nxt = {2'b10, cp[5:0]};
          endcase
        end
        2'd1: begin
          if (seg_r == 2'd0) byte_nxt = {3'b110, cp[10:6]};
          else byte_nxt = {2'b10, cp[5:0]};
        end
        default: byte_nxt = cp[7:0];
      endcase
    end
  end

  assign load = !q_empty && (!out_valid_r || out_ch.ready);
  assign q_pop = load && (seg_r == last_seg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        seg_r <= (seg_r == last_seg) ? 2'd0 : seg_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= q_cmd.kind;
      err_r <= q_cmd.err;
      last_r <= (seg_r == last_seg);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.out_kind = kind_r;
  assign out_ch.out_error_code = err_r;
  assign out_ch.out_last = last_r;

endmodule

### rtl/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output.
// An accepted request is written into the command queue, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; a \u escape producing
// N UTF-8 bytes holds the output register for all N bytes, up to QUEUE_DEPTH commands buffered.
// Reset (rst_n low, synchronous): phase machine to normal text, queue and output empty.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  logic          q_push, q_pop, q_full, q_empty;
  jsu_pkg::cmd_t q_wr_cmd, q_rd_cmd;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_rd_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/sv/jsu_result_check.sv
`timescale 1ns / 100ps
// Result checker for json_string_unescape_utf8: watches both channels, predicts the
// decoded results of each accepted request and compares them in order.
// Depends on jsu_pkg and the jsu_in_if / jsu_out_if interfaces.
module jsu_result_check (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  output int   mismatch_count,
  output int   outstanding,
  output int   results_checked,
  output int   ends_seen,
  output int   errors_seen
);

  typedef struct packed {
    logic [7:0]     data;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  err;
    logic           last;
  } result_t;

  result_t          decoded_q[$];
  jsu_pkg::phase_t  ph;
  logic [15:0]      acc;

  function automatic void add_result(logic [7:0] d, jsu_pkg::kind_t k, jsu_pkg::err_t e,
                                     logic l);
    result_t r;
    r.data = d;
    r.kind = k;
    r.err  = e;
    r.last = l;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void abort_string(jsu_pkg::err_t e);
    ph  = jsu_pkg::PH_NORMAL;
    acc = '0;
    add_result(8'h00, jsu_pkg::KIND_ERR, e, 1'b1);
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic void encode_utf8(logic [15:0] cp);
    if (cp <= 16'h007F) begin
      add_result(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end else if (cp <= 16'h07FF) begin
      add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end else begin
      add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end
  endfunction

  function automatic void unescape_step(logic [7:0] c, logic fin);
    logic [4:0]  hd;
    logic [7:0]  esc;
    logic        esc_ok;
    logic [3:0]  n;
    logic [15:0] cp;
    if (fin) begin
      case (ph)
        jsu_pkg::PH_NORMAL: abort_string(jsu_pkg::ERR_UNTERM_STR);
        jsu_pkg::PH_ESCAPE: abort_string(jsu_pkg::ERR_UNTERM_ESC);
        default:            abort_string(jsu_pkg::ERR_TRUNC_UNI);
      endcase
      return;
    end
    case (ph)
      jsu_pkg::PH_NORMAL: begin
        if (c == jsu_pkg::CH_QUOTE) add_result(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE, 1'b1);
        else if (c < jsu_pkg::CH_SPACE) abort_string(jsu_pkg::ERR_CTRL);
        else if (c == jsu_pkg::CH_BSLASH) ph = jsu_pkg::PH_ESCAPE;
        else add_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
      end
      jsu_pkg::PH_ESCAPE: begin
        esc_ok = 1'b1;
        esc    = c;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc = c;
          jsu_pkg::CH_LC_B: esc = 8'h08;
          jsu_pkg::CH_LC_F: esc = 8'h0C;
          jsu_pkg::CH_LC_N: esc = 8'h0A;
          jsu_pkg::CH_LC_R: esc = 8'h0D;
          jsu_pkg::CH_LC_T: esc = 8'h09;
          default: esc_ok = 1'b0;
        endcase
        if (c == jsu_pkg::CH_LC_U) begin
          ph  = jsu_pkg::PH_HEX0;
          acc = '0;
        end else if (esc_ok) begin
          ph = jsu_pkg::PH_NORMAL;
          add_result(esc, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
        end else begin
          abort_string(jsu_pkg::ERR_BAD_ESC);
        end
      end
      jsu_pkg::PH_BADHEX: begin
        // acc counts the digit bytes swallowed so far
        n = {1'b0, acc[2:0]} + 4'd1;
        if (n >= 4'd4) abort_string(jsu_pkg::ERR_BAD_HEX);
        else acc = {12'd0, n};
      end
      default: begin
        hd = nibble_of(c);
        if (!hd[4]) begin
          if (ph == jsu_pkg::PH_HEX3) begin
            abort_string(jsu_pkg::ERR_BAD_HEX);
          end else begin
            acc = 16'(ph - jsu_pkg::PH_HEX0 + 1);
            ph  = jsu_pkg::PH_BADHEX;
          end
        end else begin
          acc = {acc[11:0], hd[3:0]};
          if (ph == jsu_pkg::PH_HEX3) begin
            cp  = acc;
            ph  = jsu_pkg::PH_NORMAL;
            acc = '0;
            encode_utf8(cp);
          end else begin
            ph = jsu_pkg::phase_t'(ph + 3'd1);
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      ph  = jsu_pkg::PH_NORMAL;
      acc = '0;
      decoded_q.delete();
      mismatch_count  = 0;
      results_checked = 0;
      ends_seen       = 0;
      errors_seen     = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) unescape_step(in_mon.in_byte, in_mon.in_end);
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.out_byte;
        got.kind = jsu_pkg::kind_t'(out_mon.out_kind);
        got.err  = jsu_pkg::err_t'(out_mon.out_error_code);
        got.last = out_mon.out_last;
        results_checked++;
        if (got.kind == jsu_pkg::KIND_END) ends_seen++;
        if (got.kind == jsu_pkg::KIND_ERR) errors_seen++;
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got byte %0h kind %0d err %0d %s %0b",
                   $time, got.data, got.kind, got.err, "last", got.last);
        end else begin
          want = decoded_q.pop_front();
          compare_field("out_byte", want.data, got.data);
          compare_field("out_kind", 8'(want.kind), 8'(got.kind));
          compare_field("out_error_code", 8'(want.err), 8'(got.err));
          compare_field("out_last", 8'(want.last), 8'(got.last));
        end
      end
    end
    outstanding <= decoded_q.size();
  end

endmodule

### tb/sv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 100ps
// Testbench top for json_string_unescape_utf8: clock, reset, byte stimulus with random
// gaps and receiver stalls, verdict. Checking lives in jsu_result_check.
// Depends on jsu_pkg, jsu_in_if / jsu_out_if, jsu_result_check and the block itself.
module tb_json_string_unescape_utf8;

  localparam int RAND_ITEMS  = 350;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 20;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  int mismatch_count;
  int outstanding;
  int results_checked;
  int ends_seen;
  int errors_seen;

  int items_sent;
  int directed_items;
  int quiet_items;
  int cycle_count;
  bit mid_drained;

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jsu_result_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .ends_seen       (ends_seen),
    .errors_seen     (errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("json_string_unescape_utf8 verification failed");
    $finish;
  end

  // Receiver: random stalls, quiet stretches, and two long hold-offs that back up the block.
  initial begin
    int taken;
    int stall_left;
    int quiet_cycles;
    int holds_done;
    int r;
    taken        = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    holds_done   = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (stall_left == 0 && holds_done < 2 && taken >= 40 + 200 * holds_done) begin
        stall_left = 150;
        holds_done++;
      end else if (stall_left == 0 && quiet_cycles == 0) begin
        r = $urandom_range(0, 99);
        if (r < 2) quiet_cycles = $urandom_range(30, 100);
        else if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(10, 30);
      end
      if (quiet_cycles > 0) quiet_cycles--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_items = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer(input logic [7:0] b, input logic fin);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_end  <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    case (c)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_LC_B,
      jsu_pkg::CH_LC_F, jsu_pkg::CH_LC_N, jsu_pkg::CH_LC_R, jsu_pkg::CH_LC_T,
      jsu_pkg::CH_LC_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return 16'($urandom_range(16'hD800, 16'hDFFF));
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic send_hex_digits(input logic [15:0] cp, input int count);
    for (int i = 3; i > 3 - count; i--)
      offer(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
  endtask

  task automatic send_unicode(input logic [15:0] cp);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(jsu_pkg::CH_LC_U, 1'b0);
    send_hex_digits(cp, 4);
  endtask

  // \u with k good digits, then a non-hex byte
  task automatic send_bad_digit(input int k);
    logic [7:0] b;
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(jsu_pkg::CH_LC_U, 1'b0);
    send_hex_digits(16'($urandom), k);
    do b = 8'($urandom); while (is_hex(b));
    offer(b, 1'b0);
  endtask

  task automatic random_request();
    logic [7:0] b;
    logic [7:0] escapes [8];
    int pick;
    int k;
    escapes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_LC_B,
                jsu_pkg::CH_LC_F, jsu_pkg::CH_LC_N, jsu_pkg::CH_LC_R, jsu_pkg::CH_LC_T};
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      do b = 8'($urandom_range(8'h20, 8'hFF));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      offer(b, 1'b0);
    end else if (pick < 43) begin
      offer(jsu_pkg::CH_BSLASH, 1'b0);
      offer(escapes[$urandom_range(0, 7)], 1'b0);
    end else if (pick < 68) begin
      send_unicode(pick_code_point());
    end else if (pick < 73) begin
      offer(jsu_pkg::CH_QUOTE, 1'b0);
    end else if (pick < 78) begin
      offer(8'($urandom_range(0, 8'h1F)), 1'b0);
    end else if (pick < 83) begin
      offer(jsu_pkg::CH_BSLASH, 1'b0);
      do b = 8'($urandom); while (is_escape_char(b));
      offer(b, 1'b0);
    end else if (pick < 88) begin
      k = $urandom_range(0, 3);
      send_bad_digit(k);
      repeat (3 - k) offer(8'($urandom), 1'b0);
    end else if (pick < 94) begin
      case ($urandom_range(0, 3))
        0: ;
        1: offer(jsu_pkg::CH_BSLASH, 1'b0);
        2: begin
          offer(jsu_pkg::CH_BSLASH, 1'b0);
          offer(jsu_pkg::CH_LC_U, 1'b0);
          send_hex_digits(16'($urandom), $urandom_range(0, 3));
        end
        default: begin
          k = $urandom_range(0, 2);
          send_bad_digit(k);
          repeat ($urandom_range(0, 2 - k)) offer(8'($urandom), 1'b0);
        end
      endcase
      offer(8'($urandom), 1'b1);
    end else begin
      offer(8'($urandom), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    items_sent    = 0;
    quiet_items   = 0;
    mid_drained   = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_end  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, control bytes, an escape, 3-byte \u, bad digit swallowing a quote
    offer(8'h20, 1'b0);
    offer(8'h7F, 1'b0);
    offer(8'h80, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h00, 1'b0);
    offer(8'h1F, 1'b0);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(jsu_pkg::CH_LC_N, 1'b0);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(jsu_pkg::CH_LC_U, 1'b0);
    offer("F", 1'b0);
    offer("f", 1'b0);
    offer("F", 1'b0);
    offer("f", 1'b0);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(jsu_pkg::CH_LC_U, 1'b0);
    offer("g", 1'b0);
    offer(jsu_pkg::CH_QUOTE, 1'b0);
    offer(8'h00, 1'b0);
    offer("A", 1'b0);
    offer(jsu_pkg::CH_QUOTE, 1'b0);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer("x", 1'b0);
    offer(jsu_pkg::CH_BSLASH, 1'b0);
    offer(8'hA5, 1'b1);
    offer(8'h5A, 1'b1);
    directed_items = items_sent;
    wait_all_results();

    while (items_sent - directed_items < RAND_ITEMS) begin
      if (!mid_drained && items_sent - directed_items >= RAND_ITEMS / 2) begin
        wait_all_results();
        mid_drained = 1'b1;
      end
      random_request();
    end

    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d byte requests (%0d directed), checked %0d results", items_sent,
             directed_items, results_checked);
    $display("saw %0d closing quotes and %0d error results", ends_seen, errors_seen);
    if (mismatch_count == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/sv/jsu_result_check.sv
tb/sv/tb_json_string_unescape_utf8.sv
